[hdl/stcpm_pkg.sv]
package stcpm_pkg;

   // Mapping selected by the mode register. The unused code falls back to the heat map.
   typedef enum logic [1:0] {
      MODE_LUMA   = 2'd0,
      MODE_RAMP   = 2'd1,
      MODE_HEAT   = 2'd2
   } mode_type;

   localparam mode_type MODE_RESET = MODE_HEAT;

   // Band edges of the color ramp, on the offset sample u = s + 32768.
   localparam logic [15:0] BAND_ONE_END = 16'd21627;
   localparam logic [15:0] BAND_TWO_END = 16'd43254;

   localparam logic [7:0] CHANNEL_FULL = 8'd255;
   localparam logic [7:0] CHANNEL_ZERO = 8'd0;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_sample;
   } sample_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] gray;
      logic       single_component;
      logic       clamped;
      logic       last_pixel;
   } pixel_type;

endpackage

[hdl/stcpm_if.sv]
interface stcpm_req_if;
   import stcpm_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface stcpm_rsp_if;
   import stcpm_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] alpha;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] gray;
   logic       single_component;
   logic       clamped;
   logic       last_pixel;

   modport source (
      output valid, output alpha, output red, output green, output blue,
      output gray, output single_component, output clamped, output last_pixel,
      input ready
   );
   modport sink (
      input valid, input alpha, input red, input green, input blue,
      input gray, input single_component, input clamped, input last_pixel,
      output ready
   );
endinterface

[hdl/sample_to_color_pixel_mapper.sv]
// Sample-to-pixel color mapper.
//
// Each word on the request channel carries one signed Q1.15 audio sample and a
// last-sample flag; each word on the response channel carries one pixel. The
// mapping (gray, three-band color ramp, or signed heat map) is chosen by the
// two-bit mode register, written through csr_write_enable and csr_write_data.
// Change the mode only while no word is in flight.
//
// A request word is captured in an input register, mapped by short constant
// multiply logic, and lands in a result register that offers the pixel on the
// response channel. Both registers advance together, which gives a sustained
// rate of one word per clock with no bubbles while rsp ready stays high.
//
// When the receiver stalls, the result register holds its word and the input
// register fills behind it; req ready drops only when both are occupied and
// rsp ready is low. Synchronous reset empties both stages and puts the mode
// register into heat map mode.
module sample_to_color_pixel_mapper
   import stcpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   stcpm_req_if.sink   req_chan,
   stcpm_rsp_if.source rsp_chan
);

   mode_type   mode_ff;
   mode_type   mode_in;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   sample_type s1_word_ff;
   sample_type s1_word_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   pixel_type  rsp_pixel_ff;
   pixel_type  rsp_pixel_in;
   pixel_type  mapped_pixel;
   logic       rsp_advance;
   logic       s1_advance;
   logic       req_take;

   // The result register frees up whenever it is empty or its word is taken,
   // and the input register can move forward in that same cycle.
   assign rsp_advance = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance  = !s1_valid_ff || rsp_advance;
   assign req_take    = req_chan.valid && s1_advance;

   assign req_chan.ready = s1_advance;

   // Mode register; only the two low bits matter and the spare code acts as heat.
   always_comb begin
      mode_in = mode_ff;
      if (csr_write_enable) begin
         mode_in = mode_type'(csr_write_data);
      end
   end

   // Input register stage.
   always_comb begin
      s1_valid_in = s1_advance ? req_chan.valid : s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (req_take) begin
         s1_word_in.sample      = req_chan.sample;
         s1_word_in.last_sample = req_chan.last_sample;
      end
   end

   stcpm_map u_map (
      .mode      (mode_ff),
      .sample_in (s1_word_ff),
      .pixel     (mapped_pixel)
   );

   // Result register stage.
   always_comb begin
      rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;
      rsp_pixel_in = (rsp_advance && s1_valid_ff) ? mapped_pixel : rsp_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_word_ff   <= s1_word_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.alpha            = rsp_pixel_ff.alpha;
   assign rsp_chan.red              = rsp_pixel_ff.red;
   assign rsp_chan.green            = rsp_pixel_ff.green;
   assign rsp_chan.blue             = rsp_pixel_ff.blue;
   assign rsp_chan.gray             = rsp_pixel_ff.gray;
   assign rsp_chan.single_component = rsp_pixel_ff.single_component;
   assign rsp_chan.clamped          = rsp_pixel_ff.clamped;
   assign rsp_chan.last_pixel       = rsp_pixel_ff.last_pixel;

   // A gray pixel carries nothing in the color channels.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pixel_ff.single_component |->
         rsp_pixel_ff.alpha == CHANNEL_ZERO && rsp_pixel_ff.red == CHANNEL_ZERO &&
         rsp_pixel_ff.green == CHANNEL_ZERO && rsp_pixel_ff.blue == CHANNEL_ZERO)
      else $error("gray pixel has nonzero color channels");

   // A color pixel has full alpha and no gray byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pixel_ff.single_component |->
         rsp_pixel_ff.alpha == CHANNEL_FULL && rsp_pixel_ff.gray == CHANNEL_ZERO)
      else $error("color pixel has wrong alpha or gray byte");

   // Saturation in color modes only happens at the top of the blue band.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pixel_ff.clamped && !rsp_pixel_ff.single_component |->
         rsp_pixel_ff.blue == CHANNEL_FULL && rsp_pixel_ff.green == CHANNEL_ZERO)
      else $error("clamp flagged outside the blue band");

   // A word in the input register moves to the result register when it is free.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_advance |=> rsp_valid_ff)
      else $error("word lost between input and result registers");

   // Reset leaves the mapper in heat map mode.
   assert property (@(posedge clock)
      reset |=> mode_ff == MODE_HEAT)
      else $error("mode register not reset to heat map");

endmodule

[hdl/stcpm_map.sv]
module stcpm_map
   import stcpm_pkg::*;
(
   input  mode_type   mode,
   input  sample_type sample_in,
   output pixel_type  pixel
);

   logic [15:0] offset_u;
   logic [22:0] half_prod;
   logic [7:0]  half_chan;
   logic [25:0] rise_prod;
   logic        in_band_one;
   logic        in_band_two;
   logic [15:0] fade_dist;
   logic [17:0] fade_triple;
   logic signed [18:0] fade_num;
   logic        fade_sat;
   logic [24:0] fade_prod;
   logic [7:0]  fade_chan;

   // The low fifteen bits of s and of s + 32768 agree, so one product serves gray
   // and both halves of the heat map.
   assign offset_u  = {~sample_in.sample[15], sample_in.sample[14:0]};
   assign half_prod = 23'(sample_in.sample[14:0]) * 23'd255;
   assign half_chan = half_prod[22:15];

   assign rise_prod   = 26'(offset_u) * 26'd765;
   assign in_band_one = offset_u < BAND_ONE_END;
   assign in_band_two = !in_band_one && (offset_u < BAND_TWO_END);

   assign fade_dist   = in_band_two ? (offset_u - BAND_ONE_END) : (offset_u - BAND_TWO_END);
   assign fade_triple = {1'b0, fade_dist, 1'b0} + {2'b00, fade_dist};
   assign fade_num    = 19'sd65536 - $signed({1'b0, fade_triple});
   assign fade_sat    = fade_num[18];
   assign fade_prod   = 25'(fade_num[16:0]) * 25'd255;
   assign fade_chan   = fade_sat ? CHANNEL_ZERO : fade_prod[23:16];

   always_comb begin
      pixel                  = '0;
      pixel.last_pixel       = sample_in.last_sample;
      case (mode)
         MODE_LUMA: begin
            pixel.single_component = 1'b1;
            pixel.clamped          = sample_in.sample[15];
            pixel.gray             = sample_in.sample[15] ? CHANNEL_ZERO : half_chan;
         end
         MODE_RAMP: begin
            pixel.alpha = CHANNEL_FULL;
            if (in_band_one) begin
               pixel.red   = CHANNEL_FULL;
               pixel.green = rise_prod[23:16];
            end else if (in_band_two) begin
               pixel.red   = fade_chan;
               pixel.green = CHANNEL_FULL;
            end else begin
               pixel.green   = fade_chan;
               pixel.blue    = CHANNEL_FULL;
               pixel.clamped = fade_sat;
            end
         end
         default: begin
            pixel.alpha = CHANNEL_FULL;
            if (sample_in.sample[15]) begin
               pixel.blue = half_chan;
            end else if (sample_in.sample[14:0] != 15'd0) begin
               pixel.red = half_chan;
            end else begin
               pixel.green = CHANNEL_FULL;
            end
         end
      endcase
   end

endmodule
